/* sv/hqr_pkg.sv */
// shared types, codes and fixed-point helpers for the householder qr block
// no dependencies; imported by hqr_alu and householder_qr_decomposition
package hqr_pkg;

    localparam int FX_W = 56;
    localparam int DEF_MAX_ROWS = 16;
    localparam int DEF_MAX_COLS = 16;

    typedef logic signed [FX_W-1:0] fx_t;

    localparam fx_t FX_ONE = 56'sh00_0001_0000_0000;
    localparam fx_t FX_TWO = 56'sh00_0002_0000_0000;
    localparam fx_t FX_MAX = 56'sh7F_FFFF_FFFF_FFFF;
    localparam fx_t FX_MIN = 56'sh80_0000_0000_0000;

    typedef enum logic [1:0] {
        CMD_WRITE  = 2'd0,
        CMD_START  = 2'd1,
        CMD_READ_Q = 2'd2,
        CMD_READ_R = 2'd3
    } cmd_t;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_SHAPE     = 2'd1;
    localparam logic [1:0] ST_NOT_READY = 2'd2;

    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    typedef enum logic [1:0] {
        SEL_ZERO,
        SEL_Q,
        SEL_R
    } out_sel_t;

    typedef enum logic [1:0] {
        OP_MUL,
        OP_DIV,
        OP_SQRT
    } alu_op_t;

    typedef struct packed {
        logic    go;
        alu_op_t op;
    } alu_req_t;

    typedef enum logic [2:0] {
        ALU_IDLE,
        ALU_MUL,
        ALU_RND,
        ALU_PACK,
        ALU_DIV,
        ALU_SQRT,
        ALU_FIN
    } alu_state_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_WAIT,
        S_A_RD,
        S_A_MUL,
        S_A_ACC,
        S_SQ_GO,
        S_SQ_USE,
        S_B_RD,
        S_B_DIV,
        S_B_SQ,
        S_B_ACC,
        S_F_GO,
        S_F_USE,
        S_C_RD,
        S_C_MUL,
        S_C_WR,
        S_D_INIT,
        S_D_RD,
        S_D_MUL,
        S_D_ACC,
        S_E_RD,
        S_E_MUL,
        S_E_WR,
        S_NEXT_COL,
        S_CP_RD,
        S_CP_WR,
        S_QF_RD,
        S_QF_USE,
        S_QA_RD,
        S_QA_MUL,
        S_QA_ACC,
        S_QG_GO
    } qr_state_t;

    typedef enum logic [2:0] {
        S2_QG_USE,
        S2_QB_RD,
        S2_QB_MUL,
        S2_QB_WR,
        S2_Q_NEXTL,
        S2_FINISH,
        S2_NONE
    } qr_state2_t;

    function automatic fx_t fx_add(input fx_t a, input fx_t b);
        logic signed [FX_W:0] s;
        s = {a[FX_W-1], a} + {b[FX_W-1], b};
        if (s[FX_W] != s[FX_W-1]) begin
            fx_add = s[FX_W] ? FX_MIN : FX_MAX;
        end else begin
            fx_add = s[FX_W-1:0];
        end
    endfunction

    function automatic fx_t fx_sub(input fx_t a, input fx_t b);
        logic signed [FX_W:0] s;
        s = {a[FX_W-1], a} - {b[FX_W-1], b};
        if (s[FX_W] != s[FX_W-1]) begin
            fx_sub = s[FX_W] ? FX_MIN : FX_MAX;
        end else begin
            fx_sub = s[FX_W-1:0];
        end
    endfunction

endpackage

/* sv/householder_qr_decomposition.sv */
// write: no result. read q/r: the result is strobed the next cycle, one read per
// cycle while not busy. start: busy for the whole decomposition, with every product,
// divide and root done by the shared unit; n > m is strobed as a shape error instead.
// reset clears control, config (16 x 16) and the ready flag; matrix storage is not
// cleared. results are strobed for one cycle and the receiver cannot stall them.
module householder_qr_decomposition
    import hqr_pkg::*;
#(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [4:0]  cfg_data,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  command,
    input  logic [3:0]  row_index,
    input  logic [3:0]  col_index,
    input  logic signed [31:0] element_value,
    output logic        done,
    output logic signed [55:0] result_value,
    output logic [1:0]  status,
    output logic [4:0]  zero_columns
);

    localparam int MAXD    = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
    localparam int IW      = ($clog2(MAXD + 1) > 5) ? $clog2(MAXD + 1) : 5;
    localparam int RW      = $clog2(MAX_ROWS);
    localparam int CW      = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int W_DEPTH = 1 << (RW + CW);
    localparam int T_DEPTH = 1 << (2 * CW);
    localparam int S_DEPTH = 1 << RW;
    localparam int F_DEPTH = 1 << CW;

    function automatic logic [RW+CW-1:0] wa(input logic [IW-1:0] r, input logic [IW-1:0] c);
        wa = {r[RW-1:0], c[CW-1:0]};
    endfunction

    function automatic logic [2*CW-1:0] ta(input logic [IW-1:0] r, input logic [IW-1:0] c);
        ta = {r[CW-1:0], c[CW-1:0]};
    endfunction

    // control state is split in two enums to keep each narrow
    qr_state_t  state_reg, state_next;
    qr_state2_t st2_reg, st2_next;
    qr_state_t  ret_reg, ret_next;
    qr_state2_t ret2_reg, ret2_next;

    logic [4:0]    rows_reg, cols_reg;
    logic [IW-1:0] i_reg, i_next;
    logic [IW-1:0] r_reg, r_next;
    logic [IW-1:0] c_reg, c_next;
    logic [IW-1:0] l_reg, l_next;
    logic [IW-1:0] dm_reg, dm_next;
    logic [IW-1:0] dn_reg, dn_next;
    logic [IW-1:0] zc_reg, zc_next;
    fx_t           acc_reg, acc_next;
    fx_t           g_reg, g_next;
    fx_t           x0_reg, x0_next;
    fx_t           v0_reg, v0_next;
    fx_t           fac_reg, fac_next;
    logic          ready_reg, ready_next;
    logic          strobe_reg, strobe_next;
    logic [1:0]    ostat_reg, ostat_next;
    logic [4:0]    ozc_reg, ozc_next;
    out_sel_t      osel_reg, osel_next;

    logic [IW-1:0] m_eff, n_eff, row_x, col_x, r_inc, c_inc, l_inc, jdx;
    logic [RW-1:0] sidx;
    logic          in_accept, w_in_range;

    // memories: matrix, reflectors, triangular factor, scratch, scaled, factors
    fx_t w_mem [W_DEPTH];
    fx_t v_mem [W_DEPTH];
    fx_t t_mem [T_DEPTH];
    fx_t sc_mem [S_DEPTH];
    fx_t sd_mem [S_DEPTH];
    fx_t f_mem [F_DEPTH];

    logic w_we, w_re, v_we, v_re, t_we, t_re, sc_we, sc_re, sd_we, sd_re, f_we, f_re;
    logic [RW+CW-1:0] w_waddr, w_raddr, v_waddr, v_raddr;
    logic [2*CW-1:0]  t_waddr, t_raddr;
    logic [RW-1:0]    sc_waddr, sc_raddr, sd_waddr, sd_raddr;
    logic [CW-1:0]    f_waddr, f_raddr;
    fx_t w_wdata, v_wdata, t_wdata, sc_wdata, sd_wdata, f_wdata;
    fx_t w_q, v_q, t_q, sc_q, sd_q, f_q;

    alu_req_t alu_req;
    fx_t      alu_a, alu_b, alu_res;
    logic     alu_done;

    hqr_alu u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (alu_req),
        .a     (alu_a),
        .b     (alu_b),
        .done  (alu_done),
        .res   (alu_res)
    );

    assign m_eff = (rows_reg == '0) ? IW'(1) :
                   (IW'(rows_reg) > IW'(MAX_ROWS)) ? IW'(MAX_ROWS) : IW'(rows_reg);
    assign n_eff = (cols_reg == '0) ? IW'(1) :
                   (IW'(cols_reg) > IW'(MAX_COLS)) ? IW'(MAX_COLS) : IW'(cols_reg);
    assign row_x = IW'(row_index);
    assign col_x = IW'(col_index);
    assign r_inc = r_reg + IW'(1);
    assign c_inc = c_reg + IW'(1);
    assign l_inc = l_reg + IW'(1);
    assign jdx   = r_reg - i_reg;
    assign sidx  = jdx[RW-1:0];
    assign busy  = (state_reg != S_IDLE) || (st2_reg != S2_NONE);
    assign in_accept  = start && !busy;
    assign w_in_range = (row_x < IW'(MAX_ROWS)) && (col_x < IW'(MAX_COLS));

    always_comb
    begin
        state_next  = state_reg;
        st2_next    = st2_reg;
        ret_next    = ret_reg;
        ret2_next   = ret2_reg;
        i_next      = i_reg;
        r_next      = r_reg;
        c_next      = c_reg;
        l_next      = l_reg;
        dm_next     = dm_reg;
        dn_next     = dn_reg;
        zc_next     = zc_reg;
        acc_next    = acc_reg;
        g_next      = g_reg;
        x0_next     = x0_reg;
        v0_next     = v0_reg;
        fac_next    = fac_reg;
        ready_next  = ready_reg;
        strobe_next = 1'b0;
        ostat_next  = ostat_reg;
        ozc_next    = ozc_reg;
        osel_next   = osel_reg;

        w_we = 1'b0; w_re = 1'b0; v_we = 1'b0; v_re = 1'b0; t_we = 1'b0; t_re = 1'b0;
        sc_we = 1'b0; sc_re = 1'b0; sd_we = 1'b0; sd_re = 1'b0; f_we = 1'b0; f_re = 1'b0;
        w_waddr  = wa(r_reg, c_reg);
        w_raddr  = wa(r_reg, c_reg);
        v_waddr  = wa(r_reg, i_reg);
        v_raddr  = wa(r_reg, l_reg);
        t_waddr  = ta(r_reg, c_reg);
        t_raddr  = ta(row_x, col_x);
        sc_waddr = sidx;
        sc_raddr = sidx;
        sd_waddr = sidx;
        sd_raddr = sidx;
        f_waddr  = i_reg[CW-1:0];
        f_raddr  = l_reg[CW-1:0];
        w_wdata  = alu_res;
        v_wdata  = sc_q;
        t_wdata  = w_q;
        sc_wdata = alu_res;
        sd_wdata = alu_res;
        f_wdata  = alu_res;
        alu_req  = '{go: 1'b0, op: OP_MUL};
        alu_a    = sc_q;
        alu_b    = sc_q;

        if (st2_reg != S2_NONE) begin
            case (st2_reg)
                S2_QG_USE:
                begin
                    g_next   = alu_res;
                    r_next   = l_reg;
                    st2_next = S2_QB_RD;
                end
                S2_QB_RD:
                begin
                    v_re     = 1'b1;
                    w_re     = 1'b1;
                    st2_next = S2_QB_MUL;
                end
                S2_QB_MUL:
                begin
                    alu_req   = '{go: 1'b1, op: OP_MUL};
                    alu_a     = g_reg;
                    alu_b     = v_q;
                    ret2_next = S2_QB_WR;
                    st2_next  = S2_NONE;
                    state_next = S_WAIT;
                end
                S2_QB_WR:
                begin
                    w_we    = 1'b1;
                    w_wdata = fx_sub(w_q, alu_res);
                    if (r_inc == dm_reg) begin
                        if (c_inc == dn_reg) begin
                            st2_next = S2_Q_NEXTL;
                        end else begin
                            c_next     = c_inc;
                            acc_next   = '0;
                            r_next     = l_reg;
                            st2_next   = S2_NONE;
                            state_next = S_QA_RD;
                        end
                    end else begin
                        r_next   = r_inc;
                        st2_next = S2_QB_RD;
                    end
                end
                S2_Q_NEXTL:
                begin
                    if (l_reg == '0) begin
                        st2_next = S2_FINISH;
                    end else begin
                        l_next     = l_reg - IW'(1);
                        st2_next   = S2_NONE;
                        state_next = S_QF_RD;
                    end
                end
                S2_FINISH:
                begin
                    ready_next  = 1'b1;
                    strobe_next = 1'b1;
                    ostat_next  = ST_OK;
                    osel_next   = SEL_ZERO;
                    ozc_next    = zc_reg[4:0];
                    st2_next    = S2_NONE;
                    state_next  = S_IDLE;
                end
                default:
                begin
                    st2_next = S2_NONE;
                end
            endcase
        end else begin
            case (state_reg)
                S_IDLE:
                begin
                    if (start) begin
                        case (cmd_t'(command))
                            CMD_WRITE:
                            begin
                                ready_next = 1'b0;
                                if (w_in_range) begin
                                    w_we    = 1'b1;
                                    w_waddr = wa(row_x, col_x);
                                    w_wdata = {{8{element_value[31]}}, element_value, 16'b0};
                                end
                            end
                            CMD_START:
                            begin
                                dm_next = m_eff;
                                dn_next = n_eff;
                                zc_next = '0;
                                if (n_eff > m_eff) begin
                                    ready_next  = 1'b0;
                                    strobe_next = 1'b1;
                                    ostat_next  = ST_SHAPE;
                                    osel_next   = SEL_ZERO;
                                    ozc_next    = '0;
                                end else begin
                                    i_next     = '0;
                                    r_next     = '0;
                                    acc_next   = '0;
                                    state_next = S_A_RD;
                                end
                            end
                            CMD_READ_Q:
                            begin
                                strobe_next = 1'b1;
                                ozc_next    = '0;
                                w_re        = 1'b1;
                                w_raddr     = wa(row_x, col_x);
                                if (!ready_reg) begin
                                    ostat_next = ST_NOT_READY;
                                    osel_next  = SEL_ZERO;
                                end else begin
                                    ostat_next = ST_OK;
                                    osel_next  = (row_x < dm_reg && col_x < dn_reg) ?
                                                 SEL_Q : SEL_ZERO;
                                end
                            end
                            CMD_READ_R:
                            begin
                                strobe_next = 1'b1;
                                ozc_next    = '0;
                                t_re        = 1'b1;
                                if (!ready_reg) begin
                                    ostat_next = ST_NOT_READY;
                                    osel_next  = SEL_ZERO;
                                end else begin
                                    ostat_next = ST_OK;
                                    osel_next  = (row_x < dn_reg && col_x < dn_reg) ?
                                                 SEL_R : SEL_ZERO;
                                end
                            end
                            default:
                            begin
                                ready_next = ready_reg;
                            end
                        endcase
                    end
                end
                S_WAIT:
                begin
                    if (alu_done) begin
                        if (ret2_reg != S2_NONE) begin
                            st2_next  = ret2_reg;
                            ret2_next = S2_NONE;
                        end else begin
                            state_next = ret_reg;
                        end
                    end
                end
                // column norm
                S_A_RD:
                begin
                    w_re       = 1'b1;
                    w_raddr    = wa(r_reg, i_reg);
                    state_next = S_A_MUL;
                end
                S_A_MUL:
                begin
                    sc_we    = 1'b1;
                    sc_wdata = w_q;
                    if (r_reg == i_reg) begin
                        x0_next = w_q;
                    end
                    alu_req    = '{go: 1'b1, op: OP_MUL};
                    alu_a      = w_q;
                    alu_b      = w_q;
                    ret_next   = S_A_ACC;
                    state_next = S_WAIT;
                end
                S_A_ACC:
                begin
                    acc_next = fx_add(acc_reg, alu_res);
                    r_next   = r_inc;
                    state_next = (r_inc == dm_reg) ? S_SQ_GO : S_A_RD;
                end
                S_SQ_GO:
                begin
                    alu_req    = '{go: 1'b1, op: OP_SQRT};
                    alu_a      = acc_reg;
                    ret_next   = S_SQ_USE;
                    state_next = S_WAIT;
                end
                S_SQ_USE:
                begin
                    if (alu_res == '0) begin
                        // zero column: no reflector, factor zero
                        f_we       = 1'b1;
                        f_wdata    = '0;
                        zc_next    = zc_reg + IW'(1);
                        state_next = S_NEXT_COL;
                    end else begin
                        v0_next  = x0_reg[55] ? fx_sub(x0_reg, alu_res) :
                                                fx_add(x0_reg, alu_res);
                        acc_next = FX_ONE;
                        sc_we    = 1'b1;
                        sc_waddr = '0;
                        sc_wdata = FX_ONE;
                        r_next   = i_reg + IW'(1);
                        state_next = (i_reg + IW'(1) == dm_reg) ? S_F_GO : S_B_RD;
                    end
                end
                // reflector normalization
                S_B_RD:
                begin
                    sc_re      = 1'b1;
                    state_next = S_B_DIV;
                end
                S_B_DIV:
                begin
                    alu_req    = '{go: 1'b1, op: OP_DIV};
                    alu_a      = sc_q;
                    alu_b      = v0_reg;
                    ret_next   = S_B_SQ;
                    state_next = S_WAIT;
                end
                S_B_SQ:
                begin
                    sc_we      = 1'b1;
                    alu_req    = '{go: 1'b1, op: OP_MUL};
                    alu_a      = alu_res;
                    alu_b      = alu_res;
                    ret_next   = S_B_ACC;
                    state_next = S_WAIT;
                end
                S_B_ACC:
                begin
                    acc_next   = fx_add(acc_reg, alu_res);
                    r_next     = r_inc;
                    state_next = (r_inc == dm_reg) ? S_F_GO : S_B_RD;
                end
                S_F_GO:
                begin
                    alu_req    = '{go: 1'b1, op: OP_DIV};
                    alu_a      = FX_TWO;
                    alu_b      = acc_reg;
                    ret_next   = S_F_USE;
                    state_next = S_WAIT;
                end
                S_F_USE:
                begin
                    fac_next   = alu_res;
                    f_we       = 1'b1;
                    r_next     = i_reg;
                    state_next = S_C_RD;
                end
                // scaled vector and reflector store
                S_C_RD:
                begin
                    sc_re      = 1'b1;
                    state_next = S_C_MUL;
                end
                S_C_MUL:
                begin
                    v_we       = 1'b1;
                    alu_req    = '{go: 1'b1, op: OP_MUL};
                    alu_a      = fac_reg;
                    alu_b      = sc_q;
                    ret_next   = S_C_WR;
                    state_next = S_WAIT;
                end
                S_C_WR:
                begin
                    sd_we = 1'b1;
                    if (r_inc == dm_reg) begin
                        l_next     = '0;
                        state_next = S_D_INIT;
                    end else begin
                        r_next     = r_inc;
                        state_next = S_C_RD;
                    end
                end
                // apply reflector to column l
                S_D_INIT:
                begin
                    acc_next   = '0;
                    r_next     = i_reg;
                    state_next = S_D_RD;
                end
                S_D_RD:
                begin
                    sc_re      = 1'b1;
                    w_re       = 1'b1;
                    w_raddr    = wa(r_reg, l_reg);
                    state_next = S_D_MUL;
                end
                S_D_MUL:
                begin
                    alu_req    = '{go: 1'b1, op: OP_MUL};
                    alu_a      = sc_q;
                    alu_b      = w_q;
                    ret_next   = S_D_ACC;
                    state_next = S_WAIT;
                end
                S_D_ACC:
                begin
                    acc_next = fx_add(acc_reg, alu_res);
                    if (r_inc == dm_reg) begin
                        r_next     = i_reg;
                        state_next = S_E_RD;
                    end else begin
                        r_next     = r_inc;
                        state_next = S_D_RD;
                    end
                end
                S_E_RD:
                begin
                    sd_re      = 1'b1;
                    w_re       = 1'b1;
                    w_raddr    = wa(r_reg, l_reg);
                    state_next = S_E_MUL;
                end
                S_E_MUL:
                begin
                    alu_req    = '{go: 1'b1, op: OP_MUL};
                    alu_a      = acc_reg;
                    alu_b      = sd_q;
                    ret_next   = S_E_WR;
                    state_next = S_WAIT;
                end
                S_E_WR:
                begin
                    w_we    = 1'b1;
                    w_waddr = wa(r_reg, l_reg);
                    w_wdata = fx_sub(w_q, alu_res);
                    if (r_inc == dm_reg) begin
                        if (l_inc == dn_reg) begin
                            state_next = S_NEXT_COL;
                        end else begin
                            l_next     = l_inc;
                            state_next = S_D_INIT;
                        end
                    end else begin
                        r_next     = r_inc;
                        state_next = S_E_RD;
                    end
                end
                S_NEXT_COL:
                begin
                    if (i_reg + IW'(1) == dn_reg) begin
                        r_next     = '0;
                        c_next     = '0;
                        state_next = S_CP_RD;
                    end else begin
                        i_next     = i_reg + IW'(1);
                        r_next     = i_reg + IW'(1);
                        acc_next   = '0;
                        state_next = S_A_RD;
                    end
                end
                // copy r out, then load identity in place
                S_CP_RD:
                begin
                    w_re       = 1'b1;
                    state_next = S_CP_WR;
                end
                S_CP_WR:
                begin
                    t_we    = (r_reg < dn_reg);
                    w_we    = 1'b1;
                    w_wdata = (r_reg == c_reg) ? FX_ONE : '0;
                    if (c_inc == dn_reg) begin
                        c_next = '0;
                        if (r_inc == dm_reg) begin
                            l_next     = dn_reg - IW'(1);
                            state_next = S_QF_RD;
                        end else begin
                            r_next     = r_inc;
                            state_next = S_CP_RD;
                        end
                    end else begin
                        c_next     = c_inc;
                        state_next = S_CP_RD;
                    end
                end
                // build q, reflectors last to first
                S_QF_RD:
                begin
                    f_re       = 1'b1;
                    state_next = S_QF_USE;
                end
                S_QF_USE:
                begin
                    fac_next = f_q;
                    if (f_q == '0) begin
                        state_next = S_IDLE;
                        st2_next   = S2_Q_NEXTL;
                    end else begin
                        c_next     = '0;
                        acc_next   = '0;
                        r_next     = l_reg;
                        state_next = S_QA_RD;
                    end
                end
                S_QA_RD:
                begin
                    v_re       = 1'b1;
                    w_re       = 1'b1;
                    state_next = S_QA_MUL;
                end
                S_QA_MUL:
                begin
                    alu_req    = '{go: 1'b1, op: OP_MUL};
                    alu_a      = v_q;
                    alu_b      = w_q;
                    ret_next   = S_QA_ACC;
                    state_next = S_WAIT;
                end
                S_QA_ACC:
                begin
                    acc_next = fx_add(acc_reg, alu_res);
                    if (r_inc == dm_reg) begin
                        state_next = S_QG_GO;
                    end else begin
                        r_next     = r_inc;
                        state_next = S_QA_RD;
                    end
                end
                S_QG_GO:
                begin
                    alu_req    = '{go: 1'b1, op: OP_MUL};
                    alu_a      = fac_reg;
                    alu_b      = acc_reg;
                    ret2_next  = S2_QG_USE;
                    state_next = S_WAIT;
                end
                default:
                begin
                    state_next = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg  <= S_IDLE;
            st2_reg    <= S2_NONE;
            ret_reg    <= S_IDLE;
            ret2_reg   <= S2_NONE;
            rows_reg   <= 5'd16;
            cols_reg   <= 5'd16;
            dm_reg     <= IW'(1);
            dn_reg     <= IW'(1);
            zc_reg     <= '0;
            ready_reg  <= 1'b0;
            strobe_reg <= 1'b0;
            ostat_reg  <= ST_OK;
            ozc_reg    <= '0;
            osel_reg   <= SEL_ZERO;
        end else begin
            state_reg  <= state_next;
            st2_reg    <= st2_next;
            ret_reg    <= ret_next;
            ret2_reg   <= ret2_next;
            dm_reg     <= dm_next;
            dn_reg     <= dn_next;
            zc_reg     <= zc_next;
            ready_reg  <= ready_next;
            strobe_reg <= strobe_next;
            ostat_reg  <= ostat_next;
            ozc_reg    <= ozc_next;
            osel_reg   <= osel_next;
            if (cfg_write) begin
                if (cfg_index == REG_ROWS) begin
                    rows_reg <= cfg_data;
                end else begin
                    cols_reg <= cfg_data;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg   <= i_next;
        r_reg   <= r_next;
        c_reg   <= c_next;
        l_reg   <= l_next;
        acc_reg <= acc_next;
        g_reg   <= g_next;
        x0_reg  <= x0_next;
        v0_reg  <= v0_next;
        fac_reg <= fac_next;
    end

    always_ff @(posedge clk)
    begin
        if (w_we) w_mem[w_waddr] <= w_wdata;
        if (w_re) w_q <= w_mem[w_raddr];
        if (v_we) v_mem[v_waddr] <= v_wdata;
        if (v_re) v_q <= v_mem[v_raddr];
        if (t_we) t_mem[t_waddr] <= t_wdata;
        if (t_re) t_q <= t_mem[t_raddr];
        if (sc_we) sc_mem[sc_waddr] <= sc_wdata;
        if (sc_re) sc_q <= sc_mem[sc_raddr];
        if (sd_we) sd_mem[sd_waddr] <= sd_wdata;
        if (sd_re) sd_q <= sd_mem[sd_raddr];
        if (f_we) f_mem[f_waddr] <= f_wdata;
        if (f_re) f_q <= f_mem[f_raddr];
    end

    always_comb
    begin
        case (osel_reg)
            SEL_Q:   result_value = w_q;
            SEL_R:   result_value = t_q;
            default: result_value = '0;
        endcase
    end

    assign done         = strobe_reg;
    assign status       = ostat_reg;
    assign zero_columns = ozc_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobed while busy");

    a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && command == CMD_WRITE) |=> !done)
        else $error("write item produced a result");

    a_shape_err: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && command == CMD_START && n_eff > m_eff) |=> (done && status == ST_SHAPE))
        else $error("shape error not reported");

    a_not_ready_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_NOT_READY) |-> (result_value == '0))
        else $error("early read returned data");

endmodule

/* sv/hqr_alu.sv */
// shared multi-cycle arithmetic unit: rounded multiply, divide, square root
// all in saturating q24.32; depends on hqr_pkg
module hqr_alu
    import hqr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  alu_req_t req,
    input  fx_t      a,
    input  fx_t      b,
    output logic     done,
    output fx_t      res
);

    alu_state_t state_reg, state_next;

    logic [6:0]   cnt_reg;
    logic         neg_reg;
    logic [55:0]  ma_reg;
    logic [55:0]  mb_reg;
    logic [55:0]  pp_reg;
    logic [1:0]   pp_sh_reg;
    logic [111:0] prod_reg;
    logic [87:0]  dvd_reg;
    logic [55:0]  rem_reg;
    logic [87:0]  quo_reg;
    logic [47:0]  srem_reg;
    logic [43:0]  root_reg;
    logic [87:0]  mag_reg;
    fx_t          res_reg;
    logic         done_reg;

    logic [55:0]  ma_in;
    logic [55:0]  mb_in;
    logic [27:0]  a_part;
    logic [27:0]  b_part;
    logic [111:0] pp_shifted;
    logic [56:0]  div_sh;
    logic [87:0]  quo_next;
    logic [55:0]  rem_next;
    logic [47:0]  sq_sh;
    logic [47:0]  sq_trial;
    logic [87:0]  lim;
    logic [87:0]  mag_lim;

    assign ma_in = a[55] ? 56'(-a) : 56'(a);
    assign mb_in = b[55] ? 56'(-b) : 56'(b);

    // partial product select: lo*lo, lo*hi, hi*lo, hi*hi
    assign a_part = cnt_reg[1] ? ma_reg[55:28] : ma_reg[27:0];
    assign b_part = cnt_reg[0] ? mb_reg[55:28] : mb_reg[27:0];

    always_comb
    begin
        case (pp_sh_reg)
            2'd0:    pp_shifted = {56'b0, pp_reg};
            2'd1:    pp_shifted = {28'b0, pp_reg, 28'b0};
            default: pp_shifted = {pp_reg, 56'b0};
        endcase
    end

    assign div_sh = {rem_reg, dvd_reg[87]};

    always_comb
    begin
        if (div_sh >= {1'b0, mb_reg}) begin
            rem_next = 56'(div_sh - {1'b0, mb_reg});
            quo_next = {quo_reg[86:0], 1'b1};
        end else begin
            rem_next = div_sh[55:0];
            quo_next = {quo_reg[86:0], 1'b0};
        end
    end

    assign sq_sh    = {srem_reg[45:0], dvd_reg[87:86]};
    assign sq_trial = {2'b0, root_reg, 2'b01};

    assign lim     = neg_reg ? 88'h80_0000_0000_0000 : 88'h7F_FFFF_FFFF_FFFF;
    assign mag_lim = (mag_reg > lim) ? lim : mag_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ALU_IDLE:
            begin
                if (req.go) begin
                    case (req.op)
                        OP_MUL:  state_next = ALU_MUL;
                        OP_DIV:  state_next = (mb_in == '0) ? ALU_FIN : ALU_DIV;
                        OP_SQRT: state_next = (a[55] || a == '0) ? ALU_FIN : ALU_SQRT;
                        default: state_next = ALU_FIN;
                    endcase
                end
            end
            ALU_MUL:  if (cnt_reg == 7'd4) state_next = ALU_RND;
            ALU_RND:  state_next = ALU_PACK;
            ALU_PACK: state_next = ALU_FIN;
            ALU_DIV:  if (cnt_reg == '0) state_next = ALU_FIN;
            ALU_SQRT: if (cnt_reg == '0) state_next = ALU_FIN;
            ALU_FIN:  state_next = ALU_IDLE;
            default:  state_next = ALU_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ALU_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= (state_reg == ALU_FIN);
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ALU_IDLE:
            begin
                ma_reg   <= ma_in;
                mb_reg   <= mb_in;
                neg_reg  <= a[55] ^ b[55];
                cnt_reg  <= '0;
                prod_reg <= '0;
                rem_reg  <= '0;
                quo_reg  <= '0;
                srem_reg <= '0;
                root_reg <= '0;
                mag_reg  <= '0;
                if (req.op == OP_DIV) begin
                    dvd_reg <= {ma_in, 32'b0};
                    cnt_reg <= 7'd87;
                    if (mb_in == '0) begin
                        neg_reg <= 1'b0;
                    end
                end else if (req.op == OP_SQRT) begin
                    dvd_reg <= {a[55:0], 32'b0};
                    cnt_reg <= 7'd43;
                    neg_reg <= 1'b0;
                end
            end
            ALU_MUL:
            begin
                pp_reg    <= 56'(a_part * b_part);
                pp_sh_reg <= {1'b0, cnt_reg[1]} + {1'b0, cnt_reg[0]};
                if (cnt_reg != '0) begin
                    prod_reg <= prod_reg + pp_shifted;
                end
                cnt_reg <= cnt_reg + 7'd1;
            end
            ALU_RND:
            begin
                prod_reg <= prod_reg + 112'h8000_0000;
            end
            ALU_PACK:
            begin
                mag_reg <= (|prod_reg[111:96]) ? '1 : {24'b0, prod_reg[95:32]};
            end
            ALU_DIV:
            begin
                rem_reg <= rem_next;
                quo_reg <= quo_next;
                dvd_reg <= {dvd_reg[86:0], 1'b0};
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == '0) begin
                    mag_reg <= quo_next;
                end
            end
            ALU_SQRT:
            begin
                if (sq_sh >= sq_trial) begin
                    srem_reg <= sq_sh - sq_trial;
                    root_reg <= {root_reg[42:0], 1'b1};
                    if (cnt_reg == '0) begin
                        mag_reg <= {43'b0, root_reg, 1'b1};
                    end
                end else begin
                    srem_reg <= sq_sh;
                    root_reg <= {root_reg[42:0], 1'b0};
                    if (cnt_reg == '0) begin
                        mag_reg <= {43'b0, root_reg, 1'b0};
                    end
                end
                dvd_reg <= {dvd_reg[85:0], 2'b0};
                cnt_reg <= cnt_reg - 7'd1;
            end
            ALU_FIN:
            begin
                res_reg <= neg_reg ? fx_t'(-mag_lim[55:0]) : fx_t'(mag_lim[55:0]);
            end
            default:
            begin
                cnt_reg <= '0;
            end
        endcase
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule
